// ===== rtl/row_to_column_major_index_defines.svh =====
// Assertion macros for the row-to-column-major index converter.
`ifndef ROW_TO_COLUMN_MAJOR_INDEX_DEFINES_SVH
`define ROW_TO_COLUMN_MAJOR_INDEX_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCM_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RCM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== rtl/rcm_pkg.sv =====
// Package: constants, register codes, pipeline beat type and divide step.
`timescale 1ns / 1ps
package rcm_pkg;
    localparam int MAX_DIMS    = 6;
    localparam int DIMS_W      = 3;
    localparam int IDX_W       = 32;
    localparam int SIZE_W      = 32;
    localparam int OUT_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = IDX_W / DIV_BITS;
    localparam int DIM_STAGES  = DIV_STAGES + 2;
    localparam int NUM_STAGES  = MAX_DIMS * DIM_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_LST = 3'd6;

    typedef struct packed {
        logic [IDX_W-1:0]  q;
        logic [SIZE_W-1:0] rem;
        logic [OUT_W-1:0]  h;
        logic [OUT_W-1:0]  p_lo;
        logic [31:0]       p_hi;
    } beat_t;

    // One restoring divide step: shift one dividend bit into the remainder.
    function automatic logic [IDX_W+SIZE_W-1:0] div_step(
        input logic [SIZE_W-1:0] rem,
        input logic [IDX_W-1:0]  q,
        input logic [SIZE_W-1:0] d
    );
        logic [SIZE_W:0] r;
        logic            qb;
        r  = {rem, q[IDX_W-1]};
        qb = (r >= {1'b0, d});
        if (qb)
        begin
            r = r - {1'b0, d};
        end
        return {r[SIZE_W-1:0], q[IDX_W-2:0], qb};
    endfunction
endpackage

// ===== rtl/rcm_in_if.sv =====
// Input channel: C-order index beats.
`timescale 1ns / 1ps
interface rcm_in_if;
    logic                    valid;
    logic                    ready;
    logic [rcm_pkg::IDX_W-1:0] c_order_index;
    modport source (output valid, output c_order_index, input ready);
    modport sink   (input valid, input c_order_index, output ready);
endinterface

// ===== rtl/rcm_out_if.sv =====
// Output channel: Fortran-order index beats.
`timescale 1ns / 1ps
interface rcm_out_if;
    logic                      valid;
    logic                      ready;
    logic [rcm_pkg::OUT_W-1:0] fortran_order_index;
    logic                      bad_dimension;
    modport source (output valid, output fortran_order_index, output bad_dimension,
                    input ready);
    modport sink   (input valid, input fortran_order_index, input bad_dimension,
                    output ready);
endinterface

// ===== rtl/row_to_column_major_index.sv =====
// Top level: row-major to column-major linear index converter.
// Takes one C-order index per clock unless the output stalls, and returns its
// Fortran-order index from the last stage. Each of the six dimension slots,
// last dimension first, spends 16 stages on a 2-bit-per-stage restoring divide,
// one stage on two 32x32 multiplies and one on the Horner add. Slots beyond
// dims_in_use act as size 1. A zero size in use gives index 0 with bad_dimension.
// The whole pipeline stalls together when the output beat is not taken.
// Registers may only be written while no beat is in flight.
`timescale 1ns / 1ps
`include "row_to_column_major_index_defines.svh"
module row_to_column_major_index (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    rcm_in_if.sink                            in_ch,
    rcm_out_if.source                         out_ch
);
    logic [rcm_pkg::DIMS_W-1:0] dims_reg;
    logic [rcm_pkg::SIZE_W-1:0] size_reg [rcm_pkg::MAX_DIMS];
    logic [rcm_pkg::SIZE_W-1:0] eff_size [rcm_pkg::MAX_DIMS];
    logic [rcm_pkg::DIMS_W-1:0] n_act;
    logic                       bad_cfg;
    logic [rcm_pkg::CFG_IDX_W-1:0] size_sel;

    rcm_pkg::beat_t pipe_reg  [rcm_pkg::NUM_STAGES];
    rcm_pkg::beat_t pipe_next [rcm_pkg::NUM_STAGES];
    rcm_pkg::beat_t in_beat;
    logic [rcm_pkg::NUM_STAGES-1:0] valid_reg;
    logic [rcm_pkg::NUM_STAGES-1:0] valid_next;
    logic advance;

    // configuration
    assign size_sel = cfg_index - rcm_pkg::REG_DIM_SIZE_0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= rcm_pkg::DIMS_W'(1);
            for (int k = 0; k < rcm_pkg::MAX_DIMS; k++)
            begin
                size_reg[k] <= rcm_pkg::SIZE_W'(1);
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == rcm_pkg::REG_DIMS_IN_USE)
            begin
                dims_reg <= cfg_wdata[rcm_pkg::DIMS_W-1:0];
            end
            else if (cfg_index >= rcm_pkg::REG_DIM_SIZE_0 &&
                     cfg_index <= rcm_pkg::REG_DIM_SIZE_LST)
            begin
                size_reg[size_sel] <= cfg_wdata[rcm_pkg::SIZE_W-1:0];
            end
        end
    end

    always_comb
    begin
        n_act   = (dims_reg > rcm_pkg::DIMS_W'(rcm_pkg::MAX_DIMS)) ?
                  rcm_pkg::DIMS_W'(rcm_pkg::MAX_DIMS) : dims_reg;
        bad_cfg = 1'b0;
        for (int k = 0; k < rcm_pkg::MAX_DIMS; k++)
        begin
            if (rcm_pkg::DIMS_W'(k) < n_act)
            begin
                eff_size[k] = size_reg[k];
                if (size_reg[k] == '0)
                begin
                    bad_cfg = 1'b1;
                end
            end
            else
            begin
                eff_size[k] = rcm_pkg::SIZE_W'(1);
            end
        end
    end

    // pipeline
    assign advance     = !valid_reg[rcm_pkg::NUM_STAGES-1] || out_ch.ready;
    assign in_ch.ready = advance;

    always_comb
    begin
        in_beat      = '0;
        in_beat.q    = in_ch.c_order_index;
    end

    for (genvar i = 0; i < rcm_pkg::NUM_STAGES; i++)
    begin : g_stage
        localparam int SLOT  = i / rcm_pkg::DIM_STAGES;
        localparam int PHASE = i % rcm_pkg::DIM_STAGES;
        localparam int DIM   = rcm_pkg::MAX_DIMS - 1 - SLOT;

        rcm_pkg::beat_t prev;
        logic           prev_v;

        if (i == 0)
        begin : g_first
            assign prev   = in_beat;
            assign prev_v = in_ch.valid;
        end
        else
        begin : g_rest
            assign prev   = pipe_reg[i-1];
            assign prev_v = valid_reg[i-1];
        end

        assign valid_next[i] = prev_v;

        if (PHASE < rcm_pkg::DIV_STAGES)
        begin : g_div
            always_comb
            begin
                pipe_next[i] = prev;
                for (int s = 0; s < rcm_pkg::DIV_BITS; s++)
                begin
                    {pipe_next[i].rem, pipe_next[i].q} =
                        rcm_pkg::div_step(pipe_next[i].rem, pipe_next[i].q, eff_size[DIM]);
                end
            end
        end
        else if (PHASE == rcm_pkg::DIV_STAGES)
        begin : g_mul
            always_comb
            begin
                pipe_next[i]      = prev;
                pipe_next[i].p_lo = {32'd0, prev.h[31:0]} * {32'd0, eff_size[DIM]};
                // only the low 32 bits of the upper product survive the 64-bit wrap
                pipe_next[i].p_hi = prev.h[63:32] * eff_size[DIM];
            end
        end
        else
        begin : g_add
            always_comb
            begin
                pipe_next[i]     = prev;
                pipe_next[i].h   = prev.p_lo + {prev.p_hi, 32'd0} + {32'd0, prev.rem};
                pipe_next[i].rem = '0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_ch.valid               = valid_reg[rcm_pkg::NUM_STAGES-1];
    assign out_ch.bad_dimension       = bad_cfg;
    assign out_ch.fortran_order_index = bad_cfg ? '0 : pipe_reg[rcm_pkg::NUM_STAGES-1].h;

    // checks
    `RCM_ASSERT_IMPL(a_bad_zero, clk, rst_n, out_ch.valid && out_ch.bad_dimension,
        out_ch.fortran_order_index == '0, "bad dimension with nonzero index")
    `RCM_ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_ch.valid && !out_ch.ready,
        !in_ch.ready, "input taken during output stall")
    `RCM_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_ch.valid && in_ch.ready,
        valid_reg[0], "accepted beat not in first stage")
endmodule

// ===== tb/tb_row_to_column_major_index.sv =====
// Testbench for the row-major to column-major index converter, checked by a predictor.
`timescale 1ns / 1ps
module tb_row_to_column_major_index;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [rcm_pkg::OUT_W-1:0] fortran_order_index;
        logic                      bad_dimension;
    } fortran_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rcm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rcm_pkg::CFG_DATA_W-1:0] cfg_wdata;

    rcm_in_if  in_ch ();
    rcm_out_if out_ch ();

    row_to_column_major_index dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    logic [rcm_pkg::DIMS_W-1:0] shadow_dims;
    logic [rcm_pkg::SIZE_W-1:0] shadow_size [rcm_pkg::MAX_DIMS];

    logic [rcm_pkg::IDX_W-1:0] index_queue [$];
    fortran_beat_t    expected_fortran [$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 0;
    bit  driver_enable = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  beats_seen = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic fortran_beat_t convert_index(logic [rcm_pkg::IDX_W-1:0] c_index);
        fortran_beat_t r;
        logic [63:0] rest;
        logic [63:0] acc;
        logic [63:0] mult;
        logic [63:0] sub [rcm_pkg::MAX_DIMS];
        int n;
        n = (shadow_dims > rcm_pkg::MAX_DIMS) ? rcm_pkg::MAX_DIMS : int'(shadow_dims);
        r = '0;
        for (int k = 0; k < n; k++)
            if (shadow_size[k] == 0)
                r.bad_dimension = 1'b1;
        if (r.bad_dimension)
            return r;
        rest = 64'(c_index);
        for (int k = n - 1; k >= 0; k--)
        begin
            sub[k] = rest % 64'(shadow_size[k]);
            rest = rest / 64'(shadow_size[k]);
        end
        acc = 0;
        mult = 1;
        for (int k = 0; k < n; k++)
        begin
            acc += mult * sub[k];
            mult *= 64'(shadow_size[k]);
        end
        r.fortran_order_index = acc;
        return r;
    endfunction

    task automatic write_reg(logic [rcm_pkg::CFG_IDX_W-1:0] idx,
                             logic [rcm_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rcm_pkg::REG_DIMS_IN_USE)
            shadow_dims = value[rcm_pkg::DIMS_W-1:0];
        else if (idx <= rcm_pkg::REG_DIM_SIZE_LST)
            shadow_size[idx - rcm_pkg::REG_DIM_SIZE_0] = value;
    endtask

    task automatic wait_drained();
        while (index_queue.size() != 0 || expected_fortran.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [rcm_pkg::IDX_W-1:0] random_index();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            3: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [rcm_pkg::SIZE_W-1:0] random_size();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return 1;
            2: return $urandom;
            3: return 32'h8000_0000;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    function automatic logic [rcm_pkg::CFG_IDX_W-1:0] size_reg_idx(int k);
        return rcm_pkg::CFG_IDX_W'(int'(rcm_pkg::REG_DIM_SIZE_0) + k);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_fortran.push_back(convert_index(in_ch.c_order_index));
                void'(index_queue.pop_front());
            end
            if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                in_ch.valid <= 1'b1;
            end
            else
            begin
                // queue head is next item after pop
                if (driver_enable && gap_left == 0 && burst_left > 0
                    && index_queue.size() > 0)
                begin
                    burst_left--;
                    in_ch.valid <= 1'b1;
                    in_ch.c_order_index <= index_queue[0];
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        fortran_beat_t got;
        fortran_beat_t want;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else if (index_queue.size() != 0 || expected_fortran.size() != 0)
                idle_cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                got.fortran_order_index = out_ch.fortran_order_index;
                got.bad_dimension = out_ch.bad_dimension;
                if (expected_fortran.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: %h bad=%b",
                                 got.fortran_order_index, got.bad_dimension);
                end
                else
                begin
                    want = expected_fortran.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %h bad=%b, got %h bad=%b",
                                     want.fortran_order_index, want.bad_dimension,
                                     got.fortran_order_index, got.bad_dimension);
                    end
                end
                beats_seen++;
            end
            if (beats_seen % 200 == 199)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                2: out_ch.ready <= ($urandom_range(0, 1) != 0);
                default: out_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
            if (beats_seen % 200 == 199)
                beats_seen++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
        else
            out_ch.ready <= 1'b0;
    end

    initial
    begin
        int sent;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.c_order_index = '0;
        out_ch.ready = 1'b0;
        shadow_dims = rcm_pkg::DIMS_W'(1);
        for (int k = 0; k < rcm_pkg::MAX_DIMS; k++)
            shadow_size[k] = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        driver_enable = 1;

        // reset defaults, then directed shapes
        index_queue.push_back('0);
        index_queue.push_back('1);
        wait_drained();
        write_reg(rcm_pkg::REG_DIMS_IN_USE, 3);
        write_reg(size_reg_idx(0), 2);
        write_reg(size_reg_idx(1), 3);
        write_reg(size_reg_idx(2), 4);
        for (int i = 0; i < 24; i++)
            index_queue.push_back(i);
        index_queue.push_back('1);
        wait_drained();
        write_reg(rcm_pkg::REG_DIMS_IN_USE, 0);
        index_queue.push_back(32'd77);
        index_queue.push_back('1);
        wait_drained();
        write_reg(rcm_pkg::REG_DIMS_IN_USE, 7);
        for (int k = 0; k < rcm_pkg::MAX_DIMS; k++)
            write_reg(size_reg_idx(k), '1);
        index_queue.push_back('1);
        index_queue.push_back(32'hFFFF_FFFE);
        wait_drained();
        write_reg(size_reg_idx(4), 0);
        index_queue.push_back(32'd5);
        wait_drained();
        write_reg(rcm_pkg::REG_DIMS_IN_USE, 4);
        index_queue.push_back(32'd5);
        wait_drained();

        sent = 0;
        while (sent < 1250)
        begin
            int n;
            write_reg(rcm_pkg::REG_DIMS_IN_USE, $urandom_range(0, 7));
            for (int k = 0; k < rcm_pkg::MAX_DIMS; k++)
                write_reg(size_reg_idx(k),
                          ($urandom_range(0, 19) == 0) ? 0 : random_size());
            if ($urandom_range(0, 4) == 0)
                write_reg(rcm_pkg::REG_DIMS_IN_USE, $urandom_range(0, 7));
            n = $urandom_range(20, 120);
            for (int i = 0; i < n; i++)
                index_queue.push_back(random_index());
            sent += n;
            wait_drained();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
